>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, clocked on i_clk, off while reset is held
`define RQRP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Concurrent check, clocked on i_clk, active during reset too
`define RQRP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> design/rqrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rqrp_pkg;

    // Field widths of the transaction payloads
    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int ST_W    = 2;
    localparam int CNT_W   = 5;
    localparam int CAP_W   = 5;

    // Default slot storage depth
    localparam int DEPTH_DEF = 16;

    // Capacity after reset
    localparam int CAP_RST = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ       = 3'd0,
        OP_POP_HEAD  = 3'd1,
        OP_POP_TAIL  = 3'd2,
        OP_PEEK_HEAD = 3'd3,
        OP_PEEK_TAIL = 3'd4,
        OP_CLEAR     = 3'd5
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Controller -> datapath
    typedef struct packed {
        logic take;   // input transaction accepted this cycle
        logic fill;   // slot read data is ready, load it into the result
    } t_ctrl_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic reads_mem;  // offered operation needs a slot read
    } t_dp_status;

endpackage

`default_nettype wire

>>> design/ring_queue_with_rear_pop_core.sv
// channel   direction  handshake                    payload
// in        input      i_in_valid / o_in_ready      i_opcode, i_value
// out       output     o_out_valid / i_out_ready    o_data, o_status, o_count, o_is_empty
// cfg       input      i_cfg_we (no wait)           i_cfg_wdata (capacity)
//
// Enqueue, clear, empty pops/peeks and unused opcodes: result valid in the cycle after the transaction.
// Pops and peeks of a held word: the registered read port of the slot RAM, then the result register.
// A new transaction is taken the cycle after a result is registered if that result is taken.
// Reset is synchronous, active low; slot contents are not cleared and need no sweep.
// A stalled result holds the input side off until it is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ring_queue_with_rear_pop_core #(
    parameter int DEPTH = rqrp_pkg::DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [rqrp_pkg::OP_W-1:0]          i_opcode,
    input  wire logic signed [rqrp_pkg::DATA_W-1:0] i_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed [rqrp_pkg::DATA_W-1:0]      o_data,
    output logic [rqrp_pkg::ST_W-1:0]               o_status,
    output logic [rqrp_pkg::CNT_W-1:0]              o_count,
    output logic                                    o_is_empty,
    input  wire logic                               i_cfg_we,
    input  wire logic [rqrp_pkg::CAP_W-1:0]         i_cfg_wdata
);

    rqrp_pkg::t_ctrl_cmd  cmd;
    rqrp_pkg::t_dp_status sts;

    rqrp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rqrp_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_data      (o_data),
        .o_status    (o_status),
        .o_count     (o_count),
        .o_is_empty  (o_is_empty)
    );

    // Empty flag tracks the count
    `RQRP_ASSERT(a_empty_flag, o_is_empty == (o_count == '0), "empty flag disagrees with count")
    // An empty-status result always leaves the buffer empty
    `RQRP_ASSERT(a_empty_status, (o_out_valid && o_status == rqrp_pkg::ST_EMPTY) |-> o_is_empty,
        "empty status with words held")
    // A refused enqueue returns zero data and a non-empty buffer
    `RQRP_ASSERT(a_full_result,
        (o_out_valid && o_status == rqrp_pkg::ST_FULL) |-> (o_data == '0 && !o_is_empty),
        "bad refused-enqueue result")
    // Input side never opens while a slot read is outstanding
    `RQRP_ASSERT(a_one_in_flight, (cmd.take && sts.reads_mem) |=> (!o_in_ready && !o_out_valid),
        "transaction accepted during slot read")
    // Nothing is delivered during reset
    `RQRP_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

`default_nettype wire

>>> design/rqrp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rqrp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/rqrp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rqrp_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    input  wire rqrp_pkg::t_dp_status i_sts,
    output rqrp_pkg::t_ctrl_cmd      o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   take;

    // Take a new op only when idle and the result register is free or draining
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign take       = i_in_valid && o_in_ready;

    assign o_cmd.take = take;
    assign o_cmd.fill = (r_state == S_READ);

    // State and result-valid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        if (i_sts.reads_mem) begin
                            r_state     <= S_READ;
                            r_out_valid <= 1'b0;
                        end else begin
                            r_out_valid <= 1'b1;
                        end
                    end else if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_READ: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> design/rqrp_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module rqrp_dp #(
    parameter int DEPTH = rqrp_pkg::DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rqrp_pkg::t_ctrl_cmd           i_cmd,
    output rqrp_pkg::t_dp_status               o_sts,
    input  wire logic [rqrp_pkg::OP_W-1:0]     i_opcode,
    input  wire logic signed [rqrp_pkg::DATA_W-1:0] i_value,
    input  wire logic                          i_cfg_we,
    input  wire logic [rqrp_pkg::CAP_W-1:0]    i_cfg_wdata,
    output logic signed [rqrp_pkg::DATA_W-1:0] o_data,
    output logic [rqrp_pkg::ST_W-1:0]          o_status,
    output logic [rqrp_pkg::CNT_W-1:0]         o_count,
    output logic                               o_is_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CAP_RST_EFF = (DEPTH < rqrp_pkg::CAP_RST) ? DEPTH : rqrp_pkg::CAP_RST;
    localparam logic [PW-1:0] LAST_RST = PW'(CAP_RST_EFF - 1);

    // Control state
    logic [PW-1:0]              r_wp, r_rp, r_cap_last;
    logic [rqrp_pkg::CNT_W-1:0] r_held;
    // Result payload
    logic [rqrp_pkg::DATA_W-1:0] r_data;
    rqrp_pkg::t_status           r_status;

    logic [PW-1:0]              n_wp, n_rp, n_cap_last;
    logic [rqrp_pkg::CNT_W-1:0] n_held;
    logic [rqrp_pkg::DATA_W-1:0] n_data;
    rqrp_pkg::t_status           n_status;

    rqrp_pkg::t_op op;
    logic          empty, full, reads;
    logic [PW-1:0] wp_fwd, wp_back, rp_fwd, raddr;
    logic          ram_we;
    logic [rqrp_pkg::DATA_W-1:0] ram_rdata;

    assign op    = rqrp_pkg::t_op'(i_opcode);
    assign empty = (r_held == '0);
    assign full  = (32'(r_held) == (32'(r_cap_last) + 32'd1));

    // Pointer wraps against the last slot in use
    assign wp_fwd  = (r_wp == r_cap_last) ? '0 : r_wp + PW'(1);
    assign rp_fwd  = (r_rp == r_cap_last) ? '0 : r_rp + PW'(1);
    assign wp_back = (r_wp == '0) ? r_cap_last : r_wp - PW'(1);

    // Tail reads use the slot behind the write pointer
    assign raddr = (op inside {rqrp_pkg::OP_POP_TAIL, rqrp_pkg::OP_PEEK_TAIL})
                   ? wp_back : r_rp;

    // Next state and immediate result for the offered operation
    always_comb begin
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_held   = r_held;
        n_data   = '0;
        n_status = rqrp_pkg::ST_OK;
        reads    = 1'b0;
        ram_we   = 1'b0;
        case (op)
            rqrp_pkg::OP_ENQ: begin
                if (full) begin
                    n_status = rqrp_pkg::ST_FULL;
                end else begin
                    ram_we = i_cmd.take;
                    n_wp   = wp_fwd;
                    n_held = r_held + 5'd1;
                end
            end
            rqrp_pkg::OP_POP_HEAD: begin
                if (empty) begin
                    n_data   = '1;
                    n_status = rqrp_pkg::ST_EMPTY;
                end else begin
                    reads  = 1'b1;
                    n_rp   = rp_fwd;
                    n_held = r_held - 5'd1;
                end
            end
            rqrp_pkg::OP_POP_TAIL: begin
                if (empty) begin
                    n_data   = '1;
                    n_status = rqrp_pkg::ST_EMPTY;
                end else begin
                    reads  = 1'b1;
                    n_wp   = wp_back;
                    n_held = r_held - 5'd1;
                end
            end
            rqrp_pkg::OP_PEEK_HEAD, rqrp_pkg::OP_PEEK_TAIL: begin
                if (empty) begin
                    n_status = rqrp_pkg::ST_EMPTY;
                end else begin
                    reads = 1'b1;
                end
            end
            rqrp_pkg::OP_CLEAR: begin
                n_wp   = '0;
                n_rp   = '0;
                n_held = '0;
            end
            default: begin
            end
        endcase
    end

    // Capacity clamp: zero acts as one, above DEPTH acts as DEPTH
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_cap_last = '0;
        end else if (32'(i_cfg_wdata) > 32'(DEPTH)) begin
            n_cap_last = PW'(DEPTH - 1);
        end else begin
            n_cap_last = PW'(32'(i_cfg_wdata) - 32'd1);
        end
    end

    // Pointers, fill count, capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_rp       <= '0;
            r_held     <= '0;
            r_cap_last <= LAST_RST;
        end else if (i_cmd.take) begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_held <= n_held;
        end else if (i_cfg_we && empty) begin
            r_cap_last <= n_cap_last;
            r_wp       <= '0;
            r_rp       <= '0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_data   <= n_data;
            r_status <= n_status;
        end else if (i_cmd.fill) begin
            r_data <= ram_rdata;
        end
    end

    rqrp_ram #(
        .WIDTH (rqrp_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (i_value),
        .i_re    (i_cmd.take),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    assign o_sts.reads_mem = reads;

    assign o_data     = r_data;
    assign o_status   = r_status;
    assign o_count    = r_held;
    assign o_is_empty = empty;

endmodule

`default_nettype wire

>>> tb/ring_queue_with_rear_pop_core_tb.sv
`timescale 1ns / 1ps

module ring_queue_with_rear_pop_core_tb;
    import rqrp_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int CHUNK_ITEMS = 100;

    // Opcodes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
    } queue_op_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [ST_W-1:0]          status;
        logic [CNT_W-1:0]         count;
        logic                     is_empty;
    } queue_result_t;

    // DUT ports
    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [OP_W-1:0]          i_opcode;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic signed [DATA_W-1:0] o_data;
    logic [ST_W-1:0]          o_status;
    logic [CNT_W-1:0]         o_count;
    logic                     o_is_empty;
    logic                     i_cfg_we;
    logic [CAP_W-1:0]         i_cfg_wdata;

    // Stimulus and scoreboard
    queue_op_t     pending_ops[$];
    queue_result_t expected_results[$];
    queue_op_t     next_op;
    queue_result_t got_result;
    queue_result_t exp_result;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            err_cnt = 0;
    int            stall_cycles = 0;

    // Shadow copy of the queue state
    logic signed [DATA_W-1:0] shadow_slots [DEPTH];
    logic [CAP_W-1:0]         shadow_cap;
    int                       shadow_wr;
    int                       shadow_rd;
    int                       shadow_held;

    wire in_fire  = i_in_valid & o_in_ready;
    wire out_fire = o_out_valid & i_out_ready;

    ring_queue_with_rear_pop_core #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data      (o_data),
        .o_status    (o_status),
        .o_count     (o_count),
        .o_is_empty  (o_is_empty),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Pointer steps wrap at the capacity in use
    function automatic int ptr_fwd(input int p, input int cap);
        return (p + 1 >= cap) ? 0 : p + 1;
    endfunction

    function automatic int ptr_back(input int p, input int cap);
        return (p == 0 || p > cap) ? cap - 1 : p - 1;
    endfunction

    // Apply one operation to the shadow queue and return its result
    function automatic queue_result_t apply_queue_op(input logic [OP_W-1:0] op,
                                                     input logic signed [DATA_W-1:0] val);
        queue_result_t r;
        int            cap;
        cap = (shadow_cap == 0) ? 1 : ((shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap));
        r.data   = '0;
        r.status = ST_OK;
        case (op)
            OP_ENQ: begin
                if (shadow_held >= cap) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_slots[shadow_wr] = val;
                    shadow_wr = ptr_fwd(shadow_wr, cap);
                    shadow_held++;
                end
            end
            OP_POP_HEAD: begin
                if (shadow_held == 0) begin
                    r.data   = -1;
                    r.status = ST_EMPTY;
                end else begin
                    r.data = shadow_slots[shadow_rd];
                    shadow_rd = ptr_fwd(shadow_rd, cap);
                    shadow_held--;
                end
            end
            OP_POP_TAIL: begin
                if (shadow_held == 0) begin
                    r.data   = -1;
                    r.status = ST_EMPTY;
                end else begin
                    shadow_wr = ptr_back(shadow_wr, cap);
                    r.data = shadow_slots[shadow_wr];
                    shadow_held--;
                end
            end
            OP_PEEK_HEAD: begin
                if (shadow_held == 0) r.status = ST_EMPTY;
                else r.data = shadow_slots[shadow_rd];
            end
            OP_PEEK_TAIL: begin
                if (shadow_held == 0) r.status = ST_EMPTY;
                else r.data = shadow_slots[ptr_back(shadow_wr, cap)];
            end
            OP_CLEAR: begin
                shadow_wr   = 0;
                shadow_rd   = 0;
                shadow_held = 0;
            end
            default: ;
        endcase
        r.count    = shadow_held[CNT_W-1:0];
        r.is_empty = (shadow_held == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic push_op(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val);
        queue_op_t item;
        item.op    = op;
        item.value = val;
        pending_ops.push_back(item);
    endtask

    // Idle: nothing pending, nothing in flight, over a run of consecutive quiet cycles
    task automatic wait_idle();
        int quiet;
        quiet = 0;
        while (quiet < 4) begin
            @(posedge i_clk);
            if (pending_ops.size() == 0 && !i_in_valid && expected_results.size() == 0)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    // Capacity write; the block drops it while words are held
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        if (shadow_held == 0) begin
            shadow_cap = cap;
            shadow_wr  = 0;
            shadow_rd  = 0;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Bursts that lean toward filling or draining, with some clears and no-ops
    task automatic gen_traffic(input int n_items);
        int                       left;
        int                       burst;
        int                       enq_pct;
        int                       roll;
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] val;
        left = n_items;
        while (left > 0) begin
            burst   = $urandom_range(4, 40);
            enq_pct = $urandom_range(1) ? 80 : 25;
            for (int i = 0; i < burst && left > 0; i++) begin
                roll = $urandom_range(99);
                if (roll < enq_pct) begin
                    op = OP_ENQ;
                end else if (roll < 96) begin
                    case ($urandom_range(3))
                        0:       op = OP_POP_HEAD;
                        1:       op = OP_POP_TAIL;
                        2:       op = OP_PEEK_HEAD;
                        default: op = OP_PEEK_TAIL;
                    endcase
                end else if (roll < 98) begin
                    op = OP_CLEAR;
                end else begin
                    op = $urandom_range(1) ? OP_UNUSED_6 : OP_UNUSED_7;
                end
                if ($urandom_range(9) == 0) begin
                    case ($urandom_range(3))
                        0:       val = 32'sh8000_0000;
                        1:       val = 32'sh7fff_ffff;
                        2:       val = -1;
                        default: val = 0;
                    endcase
                end else begin
                    val = $urandom();
                end
                push_op(op, val);
                left--;
            end
        end
    endtask

    // Driver: next transaction once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (in_fire)
                expected_results.push_back(apply_queue_op(i_opcode, i_value));
            if (!i_in_valid || o_in_ready) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_op = pending_ops.pop_front();
                    i_in_valid <= 1'b1;
                    i_opcode   <= next_op.op;
                    i_value    <= next_op.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_fire) begin
            got_result = '{o_data, o_status, o_count, o_is_empty};
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected, data %0d", o_data));
            end else begin
                exp_result = expected_results.pop_front();
                if (got_result.data !== exp_result.data)
                    report_mismatch($sformatf("data got %0d expected %0d",
                                              got_result.data, exp_result.data));
                if (got_result.status !== exp_result.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              got_result.status, exp_result.status));
                if (got_result.count !== exp_result.count)
                    report_mismatch($sformatf("count got %0d expected %0d",
                                              got_result.count, exp_result.count));
                if (got_result.is_empty !== exp_result.is_empty)
                    report_mismatch($sformatf("is_empty got %0b expected %0b",
                                              got_result.is_empty, exp_result.is_empty));
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (in_fire || out_fire) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("ring_queue_with_rear_pop_core regression: fail");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        logic [CAP_W-1:0] cap_plan [5];
        logic [CAP_W-1:0] cap;
        cap_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17};

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_opcode      = OP_ENQ;
        i_value       = '0;
        i_out_ready   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = CAP_RST;
        send_idle_pct = 23;
        recv_idle_pct = 81;
        shadow_cap    = CAP_RST;
        shadow_wr     = 0;
        shadow_rd     = 0;
        shadow_held   = 0;
        for (int i = 0; i < DEPTH; i++) shadow_slots[i] = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty reads, unused opcodes, extreme words, both ends
        push_op(OP_PEEK_HEAD, 0);
        push_op(OP_PEEK_TAIL, 0);
        push_op(OP_POP_HEAD, 0);
        push_op(OP_POP_TAIL, 0);
        push_op(OP_UNUSED_6, 32'sh7fff_ffff);
        push_op(OP_UNUSED_7, -1);
        push_op(OP_ENQ, 32'sh8000_0000);
        push_op(OP_ENQ, 32'sh7fff_ffff);
        push_op(OP_ENQ, -1);
        push_op(OP_ENQ, 0);
        push_op(OP_PEEK_HEAD, 0);
        push_op(OP_PEEK_TAIL, 0);
        push_op(OP_POP_TAIL, 0);
        push_op(OP_PEEK_TAIL, 0);
        push_op(OP_POP_HEAD, 0);
        push_op(OP_CLEAR, 0);
        push_op(OP_POP_HEAD, 0);
        push_op(OP_ENQ, 32'sh1234_5678);

        // Capacity write while words are held is dropped
        write_capacity(5'd1);
        push_op(OP_CLEAR, 0);
        write_capacity(5'd1);
        push_op(OP_ENQ, 32'sh0bad_cafe);
        push_op(OP_ENQ, 32'sh7654_3210);
        push_op(OP_PEEK_TAIL, 0);
        push_op(OP_POP_TAIL, 0);
        push_op(OP_POP_HEAD, 0);

        // Random traffic across idle profiles and capacities
        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin send_idle_pct = 23; recv_idle_pct = 81; end
                1: begin send_idle_pct = 81; recv_idle_pct = 23; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int k = 0; k < 5; k++) begin
                cap = (p == 0) ? cap_plan[k] : 5'($urandom_range(0, 31));
                write_capacity(cap);
                gen_traffic(CHUNK_ITEMS);
                if ($urandom_range(3) != 0) push_op(OP_CLEAR, $urandom());
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0 && expected_results.size() == 0) begin
            $display("ring_queue_with_rear_pop_core regression: pass");
        end else begin
            $display("ring_queue_with_rear_pop_core regression: fail");
        end
        $finish;
    end

endmodule
